/* hw/rtl/udsu_pkg.sv */
`default_nettype none

package udsu_pkg;

    // Limits of the decoder.
    localparam int MAX_URL_BYTES        = 2048;
    localparam int MAX_ARGS             = 32;
    localparam int DEF_MAX_NAME_BYTES   = 64;
    localparam int DEF_MAX_VALUE_BYTES  = 256;
    localparam int DEF_QUEUE_DEPTH      = 4;

    // Counter widths that the fixed result fields settle.
    localparam int POS_W = 12;
    localparam int ARG_W = 6;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    // Region codes.
    localparam logic [1:0] REG_PATH  = 2'd0;
    localparam logic [1:0] REG_DELIM = 2'd1;
    localparam logic [1:0] REG_QUERY = 2'd2;
    localparam logic [1:0] REG_FRAG  = 2'd3;

    // Argument part codes.
    localparam logic [2:0] PART_NONE  = 3'd0;
    localparam logic [2:0] PART_NAME  = 3'd1;
    localparam logic [2:0] PART_EQ    = 3'd2;
    localparam logic [2:0] PART_VALUE = 3'd3;
    localparam logic [2:0] PART_AMP   = 3'd4;

    typedef struct packed {
        logic [7:0] url_byte;
        logic       end_of_url;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  decoded_byte;
        logic [10:0] position;
        logic [1:0]  region;
        logic [4:0]  arg_index;
        logic [2:0]  arg_part;
        logic        last_result;
        logic [11:0] decoded_length;
        logic [11:0] path_length;
        logic [11:0] filename_length;
        logic [11:0] query_length;
        logic [5:0]  arg_count;
        logic        too_long;
    } t_out_item;

    // Work handed from the decoder to the classifier: up to three decoded
    // bytes and the end-of-URL mark.
    typedef struct packed {
        logic [2:0][7:0] chars;
        logic [1:0]      cnt;
        logic            last;
    } t_job;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.val = 4'(b - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/udsu_front.sv */
`default_nettype none

module udsu_front import udsu_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in_item,
    input  wire logic     i_full,
    output logic          o_push,
    output t_job          o_job
);

    typedef enum logic [2:0] {
        P_NONE = 3'b001,
        P_ONE  = 3'b010,
        P_TWO  = 3'b100
    } t_pend;

    t_pend      r_pend, n_pend;
    logic [7:0] r_digit, n_digit;

    logic       accept;
    logic [7:0] b;
    t_hex       hx;
    t_hex       hx0;
    logic       do_plain;
    logic [1:0] k;
    t_job       job;

    assign accept = i_in_valid && !i_full;
    assign b      = i_in_item.url_byte;
    assign hx     = hex_decode(b);
    assign hx0    = hex_decode(r_digit);

    always_comb begin
        n_pend    = r_pend;
        n_digit   = r_digit;
        do_plain  = 1'b0;
        k         = 2'd0;
        job.chars = '0;
        job.last  = i_in_item.end_of_url;

        unique case (r_pend)
            P_NONE: begin
                do_plain = 1'b1;
            end
            P_ONE: begin
                if (hx.ok) begin
                    n_pend  = P_TWO;
                    n_digit = b;
                end else begin
                    job.chars[k] = CH_PCT;
                    k = k + 2'd1;
                    do_plain = 1'b1;
                end
            end
            P_TWO: begin
                n_pend = P_NONE;
                if (hx.ok) begin
                    job.chars[k] = {hx0.val, hx.val};
                    k = k + 2'd1;
                end else begin
                    job.chars[k] = CH_PCT;
                    k = k + 2'd1;
                    job.chars[k] = r_digit;
                    k = k + 2'd1;
                    do_plain = 1'b1;
                end
            end
            default: begin
                n_pend = P_NONE;
            end
        endcase

        if (do_plain) begin
            n_pend = P_NONE;
            if (b == CH_PLUS) begin
                job.chars[k] = CH_SPACE;
                k = k + 2'd1;
            end else if (b == CH_PCT) begin
                n_pend = P_ONE;
            end else begin
                job.chars[k] = b;
                k = k + 2'd1;
            end
        end

        // An escape cut off by the end of the URL goes out literally.
        if (i_in_item.end_of_url) begin
            if (n_pend == P_ONE) begin
                job.chars[k] = CH_PCT;
                k = k + 2'd1;
            end else if (n_pend == P_TWO) begin
                job.chars[k] = CH_PCT;
                k = k + 2'd1;
                job.chars[k] = n_digit;
                k = k + 2'd1;
            end
            n_pend = P_NONE;
        end

        job.cnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= P_NONE;
        end else if (accept) begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_digit <= n_digit;
        end
    end

    // A job is queued when it carries bytes or closes the URL.
    assign o_push = accept && (job.cnt != 2'd0 || job.last);
    assign o_job  = job;

endmodule

`default_nettype wire

/* hw/rtl/udsu_queue.sv */
`default_nettype none

module udsu_queue import udsu_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_job      o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/udsu_back.sv */
`default_nettype none

module udsu_back import udsu_pkg::*; #(
    parameter int MAX_NAME_BYTES  = DEF_MAX_NAME_BYTES,
    parameter int MAX_VALUE_BYTES = DEF_MAX_VALUE_BYTES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  wire logic i_out_stall
);

    localparam int CC_MAX = (MAX_NAME_BYTES > MAX_VALUE_BYTES) ? MAX_NAME_BYTES
                                                               : MAX_VALUE_BYTES;
    localparam int CC_W   = $clog2(CC_MAX + 1);

    // URL-wide parse state.
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_lsp, n_lsp;
    logic [POS_W-1:0] r_nsl, n_nsl;
    logic [POS_W-1:0] r_qc, n_qc;
    logic [ARG_W-1:0] r_arg, n_arg;
    logic [CC_W-1:0]  r_cc, n_cc;
    logic             r_fd, n_fd;
    logic             r_qd, n_qd;
    logic             r_in_name, n_in_name;
    logic             r_stop, n_stop;
    logic             r_ovf, n_ovf;
    logic [1:0]       r_idx, n_idx;

    logic             r_out_valid;
    t_out_item        r_out_item;

    logic             out_ready, step, produce, final_res, job_end, summary;
    logic [7:0]       c;
    logic             last_char, drop, is_delim;
    logic [ARG_W-1:0] arg_clamp, arg_total;
    t_out_item        item;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign step      = i_job_valid && out_ready;
    assign c         = i_job.chars[r_idx];
    assign last_char = (r_idx == i_job.cnt - 2'd1);
    assign drop      = (r_pos >= POS_W'(MAX_URL_BYTES));
    assign is_delim  = (c == CH_SEMI) || (c == CH_QUEST) || (c == CH_HASH) || (c == CH_AMP);
    assign arg_clamp = (r_arg >= ARG_W'(MAX_ARGS)) ? ARG_W'(MAX_ARGS - 1) : r_arg;

    always_comb begin
        n_pos     = r_pos;
        n_lsp     = r_lsp;
        n_nsl     = r_nsl;
        n_qc      = r_qc;
        n_arg     = r_arg;
        n_cc      = r_cc;
        n_fd      = r_fd;
        n_qd      = r_qd;
        n_in_name = r_in_name;
        n_stop    = r_stop;
        n_ovf     = r_ovf;
        n_idx     = r_idx;
        produce   = 1'b0;
        final_res = 1'b0;
        job_end   = 1'b0;
        summary   = 1'b0;
        arg_total = '0;
        item      = '0;

        if (step) begin
            if (i_job.cnt == 2'd0) begin
                // Closing job with no bytes left: summary only.
                summary   = 1'b1;
                final_res = 1'b1;
                job_end   = 1'b1;
            end else if (drop) begin
                // Past the length limit the rest of this job is lost.
                n_ovf   = 1'b1;
                job_end = 1'b1;
                if (i_job.last && r_idx == 2'd0) begin
                    summary   = 1'b1;
                    final_res = 1'b1;
                end
            end else begin
                produce = 1'b1;
                item.decoded_byte = c;
                item.position     = r_pos[10:0];
                item.region       = REG_PATH;
                item.arg_part     = PART_NONE;
                if (r_fd && !r_qd) begin
                    if (c == CH_HASH) begin
                        n_qd        = 1'b1;
                        item.region = REG_FRAG;
                    end else begin
                        item.region    = REG_QUERY;
                        n_qc           = r_qc + POS_W'(1);
                        item.arg_index = arg_clamp[4:0];
                        if (!r_stop) begin
                            if (c == CH_EQ && r_in_name) begin
                                n_in_name     = 1'b0;
                                n_cc          = '0;
                                item.arg_part = PART_EQ;
                            end else if (c == CH_AMP) begin
                                n_in_name     = 1'b1;
                                n_cc          = '0;
                                item.arg_part = PART_AMP;
                                n_arg         = r_arg + ARG_W'(1);
                                if (n_arg >= ARG_W'(MAX_ARGS)) begin
                                    n_stop = 1'b1;
                                end
                            end else begin
                                item.arg_part = r_in_name ? PART_NAME : PART_VALUE;
                                n_cc          = r_cc + CC_W'(1);
                                if (n_cc >= (r_in_name ? CC_W'(MAX_NAME_BYTES)
                                                       : CC_W'(MAX_VALUE_BYTES))) begin
                                    n_stop = 1'b1;
                                end
                            end
                        end
                    end
                end else if (r_qd) begin
                    item.region = REG_FRAG;
                end else if (is_delim) begin
                    n_fd        = 1'b1;
                    item.region = REG_DELIM;
                    if (c == CH_HASH) begin
                        n_qd = 1'b1;
                    end
                end else begin
                    if (c == CH_SLASH) begin
                        n_nsl = '0;
                    end else begin
                        n_nsl = r_nsl + POS_W'(1);
                    end
                end
                if (c == CH_SLASH) begin
                    n_lsp = r_pos + POS_W'(1);
                end
                n_pos = r_pos + POS_W'(1);
                // This byte closes the URL when no later byte of the job
                // can still be placed.
                final_res = i_job.last &&
                            (last_char || (r_pos + POS_W'(1) >= POS_W'(MAX_URL_BYTES)));
                job_end   = last_char || final_res;
                // Bytes of a closing job that remain at the length limit are lost.
                if (final_res && !last_char) begin
                    n_ovf = 1'b1;
                end
            end

            if (summary) begin
                produce = 1'b1;
            end

            if (final_res) begin
                arg_total = (n_arg + ARG_W'(1) > ARG_W'(MAX_ARGS)) ? ARG_W'(MAX_ARGS)
                                                                 : n_arg + ARG_W'(1);
                item.last_result     = 1'b1;
                item.decoded_length  = n_pos;
                item.path_length     = n_lsp;
                item.filename_length = n_nsl;
                item.query_length    = n_qc;
                item.arg_count       = (n_qc != '0) ? arg_total : '0;
                item.too_long        = n_ovf;
            end

            n_idx = job_end ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (step && final_res)) begin
            r_pos     <= '0;
            r_lsp     <= '0;
            r_nsl     <= '0;
            r_qc      <= '0;
            r_arg     <= '0;
            r_cc      <= '0;
            r_fd      <= 1'b0;
            r_qd      <= 1'b0;
            r_in_name <= 1'b1;
            r_stop    <= 1'b0;
            r_ovf     <= 1'b0;
            r_idx     <= 2'd0;
        end else begin
            r_pos     <= n_pos;
            r_lsp     <= n_lsp;
            r_nsl     <= n_nsl;
            r_qc      <= n_qc;
            r_arg     <= n_arg;
            r_cc      <= n_cc;
            r_fd      <= n_fd;
            r_qd      <= n_qd;
            r_in_name <= n_in_name;
            r_stop    <= n_stop;
            r_ovf     <= n_ovf;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && produce) begin
            r_out_item <= item;
        end
    end

    assign o_pop       = step && job_end;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

/* hw/rtl/url_decode_and_split_unit.sv */
// An accepted byte is registered in the job queue and then in the output register.
// One item per cycle while each item yields at most one decoded byte and no stall holds;
// a failed or cut-off escape yields more and holds the classifier until all are placed.
// A closing item whose bytes were all dropped still yields a summary result.
// Reset is synchronous and active low; it empties the job queue and the output register
// and returns the escape and split state to the start of a URL, with no sweep.
`default_nettype none

module url_decode_and_split_unit import udsu_pkg::*; #(
    parameter int MAX_NAME_BYTES  = DEF_MAX_NAME_BYTES,
    parameter int MAX_VALUE_BYTES = DEF_MAX_VALUE_BYTES,
    parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_item,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_out_item      o_out_item,
    input  wire logic      i_out_stall
);

    // The front end resolves percent escapes and plus signs. For each input
    // item it builds a job of zero to three decoded bytes, plus the
    // end-of-URL mark. Items that only open an escape produce no job.
    logic push;
    t_job push_job;

    // A short queue of jobs sits between the two halves, so the front end
    // keeps taking bytes while the classifier works through a long job or
    // waits on a stalled output.
    logic q_full, q_empty, q_pop;
    t_job q_head;

    udsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_full     (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    udsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // The back end places one decoded byte per cycle while the output is not
    // stalled: it tags the byte with its region and query argument, keeps the
    // URL totals, and attaches them to the last result of the URL. Its output
    // register holds a finished result through a stall, and classifying waits.
    udsu_back #(
        .MAX_NAME_BYTES  (MAX_NAME_BYTES),
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    // Input is held off only while the job queue is full.
    assign o_in_stall = q_full;

endmodule

`default_nettype wire

/* hw/rtl/udsu_checker.sv */
`default_nettype none

module udsu_checker import udsu_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire t_out_item o_out_item,
    input wire logic      i_out_stall
);

    // The output register is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result stays put.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Totals travel only on the closing result of a URL.
    a_totals_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last_result |->
            o_out_item.decoded_length == 12'd0 && o_out_item.path_length == 12'd0 &&
            o_out_item.filename_length == 12'd0 && o_out_item.query_length == 12'd0 &&
            o_out_item.arg_count == 6'd0 && !o_out_item.too_long)
        else $error("totals on a non-final result");

    // Argument tags appear only on query bytes.
    a_arg_tags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.region != REG_QUERY |->
            o_out_item.arg_index == 5'd0 && o_out_item.arg_part == PART_NONE)
        else $error("argument tag outside the query");

    // Closing totals are consistent with one another.
    a_totals_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last_result |->
            o_out_item.path_length <= o_out_item.decoded_length &&
            o_out_item.arg_count <= 6'(MAX_ARGS) &&
            (o_out_item.query_length != 12'd0 || o_out_item.arg_count == 6'd0))
        else $error("inconsistent totals");

endmodule

bind url_decode_and_split_unit udsu_checker u_udsu_checker (.*);

`default_nettype wire
